// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;
   localparam int HALF_PERIOD_BITS = 16;
   localparam logic [HALF_PERIOD_BITS-1:0] HALF_PERIOD_RESET = 16'd125;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STOP  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;
   localparam logic [1:0] CMD_READ  = 2'd3;

   localparam logic [3:0] ACK_BIT_INDEX = 4'd8;
   localparam logic [3:0] LAST_BIT_INDEX = 4'd9;

   typedef enum logic [10:0] {
      PH_IDLE   = 11'b000_0000_0001,
      PH_S_WAIT = 11'b000_0000_0010,
      PH_S_A    = 11'b000_0000_0100,
      PH_S_B    = 11'b000_0000_1000,
      PH_P_LOW  = 11'b000_0001_0000,
      PH_P_WAIT = 11'b000_0010_0000,
      PH_P_HIGH = 11'b000_0100_0000,
      PH_P_REL  = 11'b000_1000_0000,
      PH_B_LOW  = 11'b001_0000_0000,
      PH_B_WAIT = 11'b010_0000_0000,
      PH_B_HIGH = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] mode;
      logic [7:0] tx_byte;
      logic       master_ack;
      logic       scl_in;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_pull_low;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       slave_ack;
   } rsp_item_type;

   typedef struct packed {
      logic idle;
      logic timer_zero;
   } fsm_status_type;

endpackage

// ===== rtl/core/i2cm_if.sv =====
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [1:0] mode;
   logic [7:0] tx_byte;
   logic       master_ack;
   logic       scl_in;
   logic       sda_in;

   modport source (output valid, cmd_valid, mode, tx_byte, master_ack, scl_in, sda_in,
                   input ready);
   modport sink (input valid, cmd_valid, mode, tx_byte, master_ack, scl_in, sda_in,
                 output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_pull_low;
   logic       sda_pull_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       slave_ack;

   modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, rx_byte,
                   slave_ack, input ready);
   modport sink (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, rx_byte,
                 slave_ack, output ready);
endinterface

interface i2cm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/i2cm_fsm.sv =====
module i2cm_fsm
   import i2cm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  req_item_type                item,
   input  logic [HALF_PERIOD_BITS-1:0] half_period,
   output rsp_item_type                result,
   output fsm_status_type              status
);

   phase_type             phase_ff, phase_in;
   logic [1:0]            command_ff, command_in;
   logic [3:0]            bit_index_ff, bit_index_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic [7:0]            shift_ff, shift_in;
   logic                  ack_choice_ff, ack_choice_in;
   logic                  received_ack_ff, received_ack_in;
   logic [7:0]            rx_hold_ff, rx_hold_in;
   logic                  scl_drive_ff, scl_drive_in;
   logic                  sda_drive_ff, sda_drive_in;
   logic                  done;

   logic [TIMER_BITS-1:0] half_raw;
   logic [TIMER_BITS-1:0] half_eff;
   logic                  elapsed;

   assign half_raw = TIMER_BITS'(half_period);
   assign half_eff = (half_raw == '0) ? TIMER_BITS'(1) : half_raw;
   assign elapsed  = ((TIMER_BITS + 1)'(timer_ff) + 1'b1) >= {1'b0, half_eff};

   function automatic logic bit_sda(input logic [1:0] cmd, input logic [3:0] idx,
                                    input logic [7:0] shift, input logic ack);
      logic level;
      if (idx < ACK_BIT_INDEX) begin
         level = (cmd == CMD_WRITE) ? !shift[~idx[2:0]] : 1'b0;
      end else begin
         level = (cmd == CMD_READ) ? ack : 1'b0;
      end
      return level;
   endfunction

   always_comb begin
      phase_in        = phase_ff;
      command_in      = command_ff;
      bit_index_in    = bit_index_ff;
      timer_in        = elapsed ? timer_ff : timer_ff + 1'b1;
      shift_in        = shift_ff;
      ack_choice_in   = ack_choice_ff;
      received_ack_in = received_ack_ff;
      rx_hold_in      = rx_hold_ff;
      scl_drive_in    = scl_drive_ff;
      sda_drive_in    = sda_drive_ff;
      done            = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            timer_in = timer_ff;
            if (item.cmd_valid) begin
               command_in = item.mode;
               timer_in   = '0;
               case (item.mode)
                  CMD_START: begin
                     scl_drive_in = 1'b0;
                     sda_drive_in = 1'b0;
                     phase_in     = PH_S_WAIT;
                  end
                  CMD_STOP: begin
                     scl_drive_in = 1'b1;
                     sda_drive_in = 1'b1;
                     phase_in     = PH_P_LOW;
                  end
                  default: begin
                     bit_index_in  = '0;
                     shift_in      = (item.mode == CMD_WRITE) ? item.tx_byte : 8'd0;
                     ack_choice_in = item.master_ack;
                     scl_drive_in  = 1'b1;
                     sda_drive_in  = bit_sda(item.mode, 4'd0, shift_in, item.master_ack);
                     phase_in      = PH_B_LOW;
                  end
               endcase
            end
         end
         PH_S_WAIT: begin
            timer_in = timer_ff;
            if (item.scl_in) begin
               timer_in = '0;
               phase_in = PH_S_A;
            end
         end
         PH_S_A: begin
            if (elapsed) begin
               sda_drive_in = 1'b1;
               timer_in     = '0;
               phase_in     = PH_S_B;
            end
         end
         PH_S_B, PH_P_REL: begin
            if (elapsed) begin
               timer_in = '0;
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
         PH_P_LOW: begin
            if (elapsed) begin
               scl_drive_in = 1'b0;
               timer_in     = '0;
               phase_in     = PH_P_WAIT;
            end
         end
         PH_P_WAIT: begin
            timer_in = timer_ff;
            if (item.scl_in) begin
               timer_in = '0;
               phase_in = PH_P_HIGH;
            end
         end
         PH_P_HIGH: begin
            if (elapsed) begin
               sda_drive_in = 1'b0;
               timer_in     = '0;
               phase_in     = PH_P_REL;
            end
         end
         PH_B_LOW: begin
            if (elapsed) begin
               scl_drive_in = 1'b0;
               timer_in     = '0;
               phase_in     = PH_B_WAIT;
            end
         end
         PH_B_WAIT: begin
            timer_in = timer_ff;
            if (item.scl_in) begin
               if (bit_index_ff < ACK_BIT_INDEX) begin
                  if (command_ff == CMD_READ) begin
                     shift_in = {shift_ff[6:0], item.sda_in};
                  end
               end else if (command_ff == CMD_WRITE) begin
                  received_ack_in = !item.sda_in;
               end
               timer_in = '0;
               phase_in = PH_B_HIGH;
            end
         end
         PH_B_HIGH: begin
            if (elapsed) begin
               bit_index_in = bit_index_ff + 1'b1;
               timer_in     = '0;
               if (bit_index_in >= LAST_BIT_INDEX) begin
                  if (command_ff == CMD_READ) begin
                     rx_hold_in = shift_ff;
                  end
                  bit_index_in = '0;
                  phase_in     = PH_IDLE;
                  done         = 1'b1;
               end else begin
                  scl_drive_in = 1'b1;
                  sda_drive_in = bit_sda(command_ff, bit_index_in, shift_ff, ack_choice_ff);
                  phase_in     = PH_B_LOW;
               end
            end
         end
         default: begin
            timer_in = '0;
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         command_ff      <= CMD_START;
         bit_index_ff    <= '0;
         timer_ff        <= '0;
         shift_ff        <= '0;
         ack_choice_ff   <= 1'b0;
         received_ack_ff <= 1'b0;
         rx_hold_ff      <= '0;
         scl_drive_ff    <= 1'b0;
         sda_drive_ff    <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         command_ff      <= command_in;
         bit_index_ff    <= bit_index_in;
         timer_ff        <= timer_in;
         shift_ff        <= shift_in;
         ack_choice_ff   <= ack_choice_in;
         received_ack_ff <= received_ack_in;
         rx_hold_ff      <= rx_hold_in;
         scl_drive_ff    <= scl_drive_in;
         sda_drive_ff    <= sda_drive_in;
      end
   end

   always_comb begin
      result.scl_pull_low = scl_drive_in;
      result.sda_pull_low = sda_drive_in;
      result.busy_res     = (phase_in != PH_IDLE);
      result.done_res     = done;
      result.rx_byte      = rx_hold_in;
      result.slave_ack    = received_ack_in;
   end

   assign status.idle       = (phase_ff == PH_IDLE);
   assign status.timer_zero = (timer_ff == '0);

endmodule

// ===== rtl/core/i2c_master_byte_engine.sv =====
// Byte-level I2C master sequencer. Each request transaction is one tick of the engine: it
// carries the sampled SCL and SDA levels and, when cmd_valid is set, a command (start,
// stop, write byte or read byte). Each request yields exactly one response transaction
// with the pin drives, busy, a one-tick done flag, the last received byte and the last
// slave acknowledge, all as they stand after that tick.
// The csr channel writes the half period in engine ticks and is always ready; it should
// be written only while the engine is idle.
// The response is registered and appears in the cycle after its request is taken, and
// one request is taken every cycle while the response side keeps up.
// When the receiver stalls, the pending response holds and a new request is taken only
// in the cycle in which that response is taken, so the engine does not advance.
// Synchronous reset returns the engine to idle with both lines released, clears the
// received byte and acknowledge, empties the response register and sets the half
// period to 125.
module i2c_master_byte_engine
   import i2cm_pkg::*;
#(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input logic             clock,
   input logic             reset,
   i2cm_req_if.sink        req_chan,
   i2cm_rsp_if.source      rsp_chan,
   i2cm_csr_if.sink        csr_chan
);

   logic [HALF_PERIOD_BITS-1:0] half_period_ff;
   logic                        rsp_valid_ff;
   rsp_item_type                rsp_data_ff;
   req_item_type                item;
   rsp_item_type                result;
   fsm_status_type              status;
   logic                        req_ready;
   logic                        req_accept;

   assign req_ready  = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   always_comb begin
      item.cmd_valid  = req_chan.cmd_valid;
      item.mode       = req_chan.mode;
      item.tx_byte    = req_chan.tx_byte;
      item.master_ack = req_chan.master_ack;
      item.scl_in     = req_chan.scl_in;
      item.sda_in     = req_chan.sda_in;
   end

   i2cm_fsm #(
      .TIMER_BITS(TIMER_BITS)
   ) u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .item       (item),
      .half_period(half_period_ff),
      .result     (result),
      .status     (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
      end else if (csr_chan.valid) begin
         half_period_ff <= csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.scl_pull_low = rsp_data_ff.scl_pull_low;
   assign rsp_chan.sda_pull_low = rsp_data_ff.sda_pull_low;
   assign rsp_chan.busy_res     = rsp_data_ff.busy_res;
   assign rsp_chan.done_res     = rsp_data_ff.done_res;
   assign rsp_chan.rx_byte      = rsp_data_ff.rx_byte;
   assign rsp_chan.slave_ack    = rsp_data_ff.slave_ack;

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_accept)
      else $error("Request taken while the response is stalled.");

   a_accept_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("Accepted request left no response.");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.done_res && rsp_data_ff.busy_res))
      else $error("Done reported while still busy.");

   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      status.idle |-> status.timer_zero)
      else $error("Half period timer not cleared in idle.");

endmodule
